/* src/almap_pkg.sv */
package almap_pkg;

	// field and state widths
	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 11;
	localparam int SUM_W    = 18;
	localparam int CNT_W    = 8;

	// full scale of the sensor, used by the inversion
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1024);

	// hysteresis divisor applied to the level span
	localparam int HYSTERESIS = 10;

	// band width as span * ceil(2^HYST_SHIFT / HYSTERESIS) >> HYST_SHIFT,
	// exact for every 11-bit span and any divisor up to 64
	localparam int HYST_SHIFT = 18;
	localparam int HYST_MUL_W = HYST_SHIFT + 1;
	localparam int BAND_W     = LEVEL_W + HYST_MUL_W;
	localparam logic [HYST_MUL_W-1:0] HYST_RECIP =
		HYST_MUL_W'((2 ** HYST_SHIFT + HYSTERESIS - 1) / HYSTERESIS);

	// serial divider: dividend holds the sample sum or avg * steps + span / 2
	localparam int DIV_W     = 2 * LEVEL_W;
	localparam int DIVR_W    = LEVEL_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LVL_FLOOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LVL_CEIL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRT_FLOOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BRT_CEIL  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd6;

	typedef struct packed {
		logic               invert_sample;
		logic [LEVEL_W-1:0] level_floor;
		logic [LEVEL_W-1:0] level_ceiling;
		logic [LEVEL_W-1:0] brightness_steps;
		logic [LEVEL_W-1:0] brightness_floor;
		logic [LEVEL_W-1:0] brightness_ceiling;
		logic [CNT_W-1:0]   samples_per_average;
	} cfg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV_AVG,
		B_CMP,
		B_DIV_SCALE,
		B_EMIT
	} back_state_t;

	// a sample count of zero behaves as one
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
		return (n == '0) ? CNT_W'(1) : n;
	endfunction

endpackage

/* src/almap_front.sv */
module almap_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  almap_pkg::cfg_t                cfg,
	input  logic                           in_valid,
	input  logic [almap_pkg::SAMPLE_W-1:0] light_sample,
	input  logic                           q_full,
	output logic                           in_stall,
	output logic                           push,
	output logic [almap_pkg::SUM_W-1:0]    push_sum
);

	logic [almap_pkg::SUM_W-1:0]   sum_q;
	logic [almap_pkg::CNT_W-1:0]   cnt_q;
	logic [almap_pkg::LEVEL_W-1:0] s_raw;
	logic [almap_pkg::LEVEL_W-1:0] s_inv;
	logic [almap_pkg::LEVEL_W-1:0] s_clamp;
	logic [almap_pkg::LEVEL_W-1:0] contrib;
	logic [almap_pkg::SUM_W-1:0]   sum_nx;
	logic [almap_pkg::CNT_W-1:0]   cnt_nx;
	logic                          window_ok;
	logic                          accept;
	logic                          decide;

	always_comb begin
		s_raw     = almap_pkg::LEVEL_W'(light_sample);
		s_inv     = cfg.invert_sample ? (almap_pkg::LEVEL_FULL - s_raw) : s_raw;
		window_ok = cfg.level_ceiling > cfg.level_floor;
		s_clamp   = s_inv;
		if (s_clamp < cfg.level_floor) begin
			s_clamp = cfg.level_floor;
		end
		if (s_clamp > cfg.level_ceiling) begin
			s_clamp = cfg.level_ceiling;
		end
		contrib = window_ok ? (s_clamp - cfg.level_floor) : '0;
		sum_nx  = sum_q + almap_pkg::SUM_W'(contrib);
		cnt_nx  = cnt_q + almap_pkg::CNT_W'(1);
		decide  = cnt_nx >= almap_pkg::eff_count(cfg.samples_per_average);
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && decide && window_ok;
	assign push_sum = sum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (decide) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

endmodule

/* src/almap_fifo.sv */
module almap_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [almap_pkg::SUM_W-1:0] wdata,
	input  logic                        pop,
	output logic [almap_pkg::SUM_W-1:0] rdata,
	output logic                        full,
	output logic                        not_empty
);

	logic [almap_pkg::SUM_W-1:0]  mem_q [almap_pkg::QDEPTH];
	logic [almap_pkg::QPTR_W-1:0] wptr_q;
	logic [almap_pkg::QPTR_W-1:0] rptr_q;
	logic [almap_pkg::QCNT_W-1:0] cnt_q;

	assign full      = cnt_q == almap_pkg::QCNT_W'(almap_pkg::QDEPTH);
	assign not_empty = cnt_q != '0;
	assign rdata     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == almap_pkg::QPTR_W'(almap_pkg::QDEPTH - 1)) ?
					'0 : wptr_q + almap_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == almap_pkg::QPTR_W'(almap_pkg::QDEPTH - 1)) ?
					'0 : rptr_q + almap_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + almap_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - almap_pkg::QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

/* src/almap_div.sv */
module almap_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [almap_pkg::DIV_W-1:0]  dividend,
	input  logic [almap_pkg::DIVR_W-1:0] divisor,
	output logic                         done,
	output logic [almap_pkg::DIV_W-1:0]  quotient
);

	logic [almap_pkg::DIV_W-1:0]     work_q;
	logic [almap_pkg::DIVR_W-1:0]    rem_q;
	logic [almap_pkg::DIVR_W-1:0]    dvs_q;
	logic [almap_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [almap_pkg::DIVR_W:0]      rem_sh;
	logic                            qbit;
	logic [almap_pkg::DIVR_W:0]      rem_nx;

	// one restoring step per cycle, quotient bits shift in behind the dividend
	always_comb begin
		rem_sh = {rem_q, work_q[almap_pkg::DIV_W-1]};
		qbit   = rem_sh >= {1'b0, dvs_q};
		rem_nx = qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[almap_pkg::DIV_W-2:0], qbit};
			rem_q  <= rem_nx[almap_pkg::DIVR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= almap_pkg::DIV_CNT_W'(almap_pkg::DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - almap_pkg::DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

/* src/almap_back.sv */
module almap_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  almap_pkg::cfg_t               cfg,
	input  logic                          q_not_empty,
	input  logic [almap_pkg::SUM_W-1:0]   q_sum,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [almap_pkg::LEVEL_W-1:0] brightness
);

	almap_pkg::back_state_t state_q, state_nx;

	logic [almap_pkg::LEVEL_W-1:0]  held_q;
	logic [almap_pkg::LEVEL_W-1:0]  avg_q;
	logic [almap_pkg::LEVEL_W-1:0]  step_q;
	logic [almap_pkg::LEVEL_W-1:0]  res_q;
	logic                           out_valid_q;
	logic [almap_pkg::LEVEL_W-1:0]  out_q;

	logic [almap_pkg::LEVEL_W-1:0]  span;
	logic [almap_pkg::BAND_W-1:0]   band_prod;
	logic                           div_start;
	logic [almap_pkg::DIV_W-1:0]    div_dvd;
	logic [almap_pkg::DIVR_W-1:0]   div_dvs;
	logic                           div_done;
	logic [almap_pkg::DIV_W-1:0]    div_q;
	logic [almap_pkg::LEVEL_W-1:0]  avg_sat;
	logic [almap_pkg::LEVEL_W:0]    upper;
	logic [almap_pkg::LEVEL_W:0]    lower;
	logic                           inside_band;
	logic [almap_pkg::DIV_W-1:0]    prod;
	logic [almap_pkg::LEVEL_W-1:0]  b_clamp;
	logic                           out_free;

	almap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	// span is only used when the window is non-empty, the front drops the rest
	assign span     = cfg.level_ceiling - cfg.level_floor;
	assign out_free = !out_valid_q || !out_stall;

	// hysteresis band width by reciprocal multiply
	assign band_prod = almap_pkg::BAND_W'(span) * almap_pkg::BAND_W'(almap_pkg::HYST_RECIP);

	always_comb begin
		avg_sat = (div_q > almap_pkg::DIV_W'(span)) ? span : div_q[almap_pkg::LEVEL_W-1:0];

		upper       = {1'b0, held_q} + {1'b0, step_q};
		lower       = {1'b0, avg_q} + {1'b0, step_q};
		inside_band = ({1'b0, avg_q} <= upper) && (lower >= {1'b0, held_q});

		prod = almap_pkg::DIV_W'(avg_q) * almap_pkg::DIV_W'(cfg.brightness_steps);

		if (div_q < almap_pkg::DIV_W'(cfg.brightness_floor)) begin
			b_clamp = cfg.brightness_floor;
		end else if (div_q > almap_pkg::DIV_W'(cfg.brightness_ceiling)) begin
			b_clamp = cfg.brightness_ceiling;
		end else begin
			b_clamp = div_q[almap_pkg::LEVEL_W-1:0];
		end
	end

	always_comb begin
		state_nx  = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		div_dvd   = almap_pkg::DIV_W'(q_sum);
		div_dvs   = almap_pkg::DIVR_W'(almap_pkg::eff_count(cfg.samples_per_average));
		case (state_q)
			almap_pkg::B_IDLE: begin
				if (q_not_empty) begin
					pop       = 1'b1;
					div_start = 1'b1;
					state_nx  = almap_pkg::B_DIV_AVG;
				end
			end
			almap_pkg::B_DIV_AVG: begin
				if (div_done) begin
					state_nx = almap_pkg::B_CMP;
				end
			end
			almap_pkg::B_CMP: begin
				if (inside_band) begin
					state_nx = almap_pkg::B_IDLE;
				end else begin
					div_start = 1'b1;
					div_dvd   = prod + almap_pkg::DIV_W'(span >> 1);
					div_dvs   = span;
					state_nx  = almap_pkg::B_DIV_SCALE;
				end
			end
			almap_pkg::B_DIV_SCALE: begin
				if (div_done) begin
					state_nx = almap_pkg::B_EMIT;
				end
			end
			almap_pkg::B_EMIT: begin
				if (out_free) begin
					state_nx = almap_pkg::B_IDLE;
				end
			end
			default: begin
				state_nx = almap_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= almap_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == almap_pkg::B_DIV_AVG && div_done) begin
			avg_q  <= avg_sat;
			step_q <= band_prod[almap_pkg::HYST_SHIFT +: almap_pkg::LEVEL_W];
		end
		if (state_q == almap_pkg::B_DIV_SCALE && div_done) begin
			res_q <= b_clamp;
		end
		if (state_q == almap_pkg::B_EMIT && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == almap_pkg::B_CMP && !inside_band) begin
				held_q <= avg_q;
			end
			if (state_q == almap_pkg::B_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign brightness = out_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == almap_pkg::B_IDLE)
		else $error("queue read outside idle");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == almap_pkg::B_DIV_AVG || state_q == almap_pkg::B_DIV_SCALE))
		else $error("divider finished with no division pending");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == almap_pkg::B_EMIT && out_free |=> out_valid_q && out_q == $past(res_q))
		else $error("result not loaded into output register");

endmodule

/* src/ambient_light_brightness_mapper_top.sv */
// ambient light to display brightness mapper
//
// input channel: in_valid / in_stall with light_sample, one 10-bit sensor
// reading per transfer. output channel: out_valid / out_stall with brightness,
// sent only when the averaged level moves outside the hysteresis band.
// configuration: wr_en / wr_index / wr_data write one register per cycle, to be
// used only while the block is idle.
//
// the front takes one sample per cycle while the queue is not full and
// accumulates it; every samples_per_average samples the sum goes into a
// two-entry queue unless the level window is empty. the back runs a 22-step
// serial divider for the average and for the brightness scaling; the band
// width is a reciprocal multiply. a decision reads the queue, averages, checks
// the band and, if outside it, scales and loads the output register. in_stall
// rises only while the queue is full, when decisions outpace the back
//
// when the receiver stalls, the result holds in the output register and the
// back keeps working on the next decision until it needs that register.
// reset clears configuration to its defaults, the accumulator, the sample
// count, the held level, the queue and the output valid.
module ambient_light_brightness_mapper_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [almap_pkg::SAMPLE_W-1:0]    light_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [almap_pkg::LEVEL_W-1:0]     brightness,
	input  logic                              wr_en,
	input  logic [almap_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [almap_pkg::LEVEL_W-1:0]     wr_data
);

	almap_pkg::cfg_t cfg_q;

	logic                        q_full;
	logic                        q_not_empty;
	logic                        q_push;
	logic                        q_pop;
	logic [almap_pkg::SUM_W-1:0] q_wdata;
	logic [almap_pkg::SUM_W-1:0] q_rdata;

	// configuration registers with their reset defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_sample       <= 1'b0;
			cfg_q.level_floor         <= almap_pkg::LEVEL_W'(0);
			cfg_q.level_ceiling       <= almap_pkg::LEVEL_W'(1024);
			cfg_q.brightness_steps    <= almap_pkg::LEVEL_W'(256);
			cfg_q.brightness_floor    <= almap_pkg::LEVEL_W'(0);
			cfg_q.brightness_ceiling  <= almap_pkg::LEVEL_W'(256);
			cfg_q.samples_per_average <= almap_pkg::CNT_W'(8);
		end else if (wr_en) begin
			case (wr_index)
				almap_pkg::REG_INVERT:    cfg_q.invert_sample      <= wr_data[0];
				almap_pkg::REG_LVL_FLOOR: cfg_q.level_floor        <= wr_data;
				almap_pkg::REG_LVL_CEIL:  cfg_q.level_ceiling      <= wr_data;
				almap_pkg::REG_STEPS:     cfg_q.brightness_steps   <= wr_data;
				almap_pkg::REG_BRT_FLOOR: cfg_q.brightness_floor   <= wr_data;
				almap_pkg::REG_BRT_CEIL:  cfg_q.brightness_ceiling <= wr_data;
				almap_pkg::REG_SAMPLES: begin
					cfg_q.samples_per_average <= wr_data[almap_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: invert, clamp, offset and accumulate samples
	almap_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.light_sample (light_sample),
		.q_full       (q_full),
		.in_stall     (in_stall),
		.push         (q_push),
		.push_sum     (q_wdata)
	);

	// queue of finished sums waiting for a decision
	almap_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// back: average, hysteresis check and brightness scaling
	almap_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_sum       (q_rdata),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.brightness  (brightness)
	);

endmodule
